### src/krt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package krt_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int ENTRY_IDX_W     = 7;

  typedef logic signed [31:0] word_t;
  typedef logic [1:0]         kind_t;
  typedef logic [1:0]         status_t;

  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_LOOKUP = 2'd1;
  localparam kind_t KIND_ADJUST = 2'd2;
  localparam kind_t KIND_SET    = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_EXISTS    = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  typedef enum logic {
    ALU_EQ  = 1'b0,
    ALU_ADD = 1'b1
  } alu_op_t;

  // one stored record as read back from the table
  typedef struct packed {
    word_t key;
    word_t price;
    word_t qty;
  } rec_t;

  // write strobes and data towards the table
  typedef struct packed {
    logic  key_we;
    logic  price_we;
    logic  qty_we;
    word_t key;
    word_t price;
    word_t qty;
  } wr_t;

endpackage
`default_nettype wire

### src/krt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface krt_in_if;
  import krt_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  word_t part_key;
  word_t price_value;
  word_t quantity_value;
  modport source (output valid, kind, part_key, price_value, quantity_value, input ready);
  modport sink   (input valid, kind, part_key, price_value, quantity_value, output ready);
endinterface

interface krt_out_if;
  import krt_pkg::*;
  logic                         valid;
  logic                         ready;
  status_t                      status;
  logic [krt_pkg::ENTRY_IDX_W-1:0] entry_index;
  word_t                        price_out;
  word_t                        quantity_out;
  modport source (output valid, status, entry_index, price_out, quantity_out, input ready);
  modport sink   (input valid, status, entry_index, price_out, quantity_out, output ready);
endinterface
`default_nettype wire

### src/krt_alu.sv
`timescale 1ns / 1ps
`default_nettype none
module krt_alu (
  input  krt_pkg::alu_op_t op,
  input  krt_pkg::word_t   a,
  input  krt_pkg::word_t   b,
  output logic             eq,
  output krt_pkg::word_t   result
);
  import krt_pkg::*;

  word_t sum;
  logic  ovf;

  assign sum = a + b;
  // operands share a sign and the sum flips it
  assign ovf = (a[31] == b[31]) && (sum[31] != a[31]);
  assign eq  = (a == b);

  always_comb begin
    unique case (op)
      ALU_ADD: begin
        if (ovf) result = a[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else     result = sum;
      end
      default: result = a ^ b;
    endcase
  end

endmodule
`default_nettype wire

### src/krt_store.sv
`timescale 1ns / 1ps
`default_nettype none
module krt_store #(
  parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF,
  parameter int IDXW        = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic [IDXW-1:0]   wr_addr,
  input  krt_pkg::wr_t      wr,
  input  logic [IDXW-1:0]   rd_addr,
  output krt_pkg::rec_t     rd_rec
);
  import krt_pkg::*;

  word_t key_mem   [TABLE_DEPTH];
  word_t price_mem [TABLE_DEPTH];
  word_t qty_mem   [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.key_we)   key_mem[wr_addr]   <= wr.key;
    if (wr.price_we) price_mem[wr_addr] <= wr.price;
    if (wr.qty_we)   qty_mem[wr_addr]   <= wr.qty;
  end

  always_ff @(posedge clk) begin
    rd_rec.key   <= key_mem[rd_addr];
    rd_rec.price <= price_mem[rd_addr];
    rd_rec.qty   <= qty_mem[rd_addr];
  end

endmodule
`default_nettype wire

### src/keyed_record_table.sv
// request flow: a miss or an insert scans every filled entry, a hit on lookup, adjust or set
// price stops the scan at its slot and passes the update state, a duplicate insert stops at its
// slot and an insert into a full table skips the scan; the result then waits for a free output
// register; throughput: one request in flight, taken only once the last result is registered;
// the key scan reads one stored key per cycle through the single table read port and shared comparator
// reset: synchronous, active low; clears the entry count and control, table contents undefined
`timescale 1ns / 1ps
`default_nettype none
module keyed_record_table #(
  parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  krt_in_if.sink    in_chan,
  krt_out_if.source out_chan
);
  import krt_pkg::*;

  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_ACT  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  kind_t  req_kind_r, req_kind_nxt;
  word_t  req_key_r, req_key_nxt, req_price_r, req_price_nxt, req_qty_r, req_qty_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt, scan_r, scan_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [IDXW-1:0] cmp_addr_r, cmp_addr_nxt, slot_r, slot_nxt;
  word_t  hit_price_r, hit_price_nxt, hit_qty_r, hit_qty_nxt;
  status_t res_status_r, res_status_nxt;
  logic [IDXW-1:0] res_idx_r, res_idx_nxt;
  word_t  res_price_r, res_price_nxt, res_qty_r, res_qty_nxt;
  logic   out_vld_r, out_vld_nxt;
  status_t out_status_r, out_status_nxt;
  logic [ENTRY_IDX_W-1:0] out_idx_r, out_idx_nxt;
  word_t  out_price_r, out_price_nxt, out_qty_r, out_qty_nxt;

  logic            rd_issue;
  logic [IDXW-1:0] rd_addr, wr_addr;
  wr_t             wr;
  rec_t            rd_rec;
  alu_op_t         alu_op;
  word_t           alu_a, alu_b, alu_res;
  logic            alu_eq;
  logic [IDXW+ENTRY_IDX_W-1:0] idx_ext;

  krt_store #(.TABLE_DEPTH(TABLE_DEPTH), .IDXW(IDXW)) u_store (
    .clk     (clk),
    .wr_addr (wr_addr),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_rec  (rd_rec)
  );

  krt_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .eq     (alu_eq),
    .result (alu_res)
  );

  assign rd_issue = (scan_r < cnt_r);
  assign rd_addr  = rd_issue ? scan_r[IDXW-1:0] : '0;
  assign idx_ext  = {{ENTRY_IDX_W{1'b0}}, res_idx_r};

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_vld_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.entry_index  = out_idx_r;
  assign out_chan.price_out    = out_price_r;
  assign out_chan.quantity_out = out_qty_r;

  always_comb begin
    if (state_r == S_ACT) begin
      alu_op = ALU_ADD;
      alu_a  = hit_qty_r;
      alu_b  = req_qty_r;
    end else begin
      alu_op = ALU_EQ;
      alu_a  = rd_rec.key;
      alu_b  = req_key_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    req_kind_nxt   = req_kind_r;
    req_key_nxt    = req_key_r;
    req_price_nxt  = req_price_r;
    req_qty_nxt    = req_qty_r;
    cnt_nxt        = cnt_r;
    scan_nxt       = scan_r;
    cmp_vld_nxt    = 1'b0;
    cmp_addr_nxt   = cmp_addr_r;
    slot_nxt       = slot_r;
    hit_price_nxt  = hit_price_r;
    hit_qty_nxt    = hit_qty_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_price_nxt  = res_price_r;
    res_qty_nxt    = res_qty_r;
    out_vld_nxt    = out_vld_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_price_nxt  = out_price_r;
    out_qty_nxt    = out_qty_r;
    wr_addr        = slot_r;
    wr             = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          req_kind_nxt  = in_chan.kind;
          req_key_nxt   = in_chan.part_key;
          req_price_nxt = in_chan.price_value;
          req_qty_nxt   = in_chan.quantity_value;
          scan_nxt      = '0;
          if (in_chan.kind == KIND_INSERT && cnt_r == FULL_CNT) begin
            res_status_nxt = ST_FULL;
            res_idx_nxt    = '0;
            res_price_nxt  = '0;
            res_qty_nxt    = '0;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read of the next slot overlaps the compare of the previous one
        cmp_vld_nxt  = rd_issue;
        cmp_addr_nxt = scan_r[IDXW-1:0];
        scan_nxt     = scan_r + 1'b1;
        if (cmp_vld_r && alu_eq) begin
          slot_nxt = cmp_addr_r;
          if (req_kind_r == KIND_INSERT) begin
            res_status_nxt = ST_EXISTS;
            res_idx_nxt    = '0;
            res_price_nxt  = '0;
            res_qty_nxt    = '0;
            state_nxt      = S_DONE;
          end else begin
            hit_price_nxt = rd_rec.price;
            hit_qty_nxt   = rd_rec.qty;
            state_nxt     = S_ACT;
          end
        end else if (!rd_issue) begin
          if (req_kind_r == KIND_INSERT) begin
            wr_addr        = cnt_r[IDXW-1:0];
            wr.key_we      = 1'b1;
            wr.price_we    = 1'b1;
            wr.qty_we      = 1'b1;
            wr.key         = req_key_r;
            wr.price       = req_price_r;
            wr.qty         = req_qty_r;
            cnt_nxt        = cnt_r + 1'b1;
            res_status_nxt = ST_OK;
            res_idx_nxt    = cnt_r[IDXW-1:0];
            res_price_nxt  = req_price_r;
            res_qty_nxt    = req_qty_r;
          end else begin
            res_status_nxt = ST_NOT_FOUND;
            res_idx_nxt    = '0;
            res_price_nxt  = '0;
            res_qty_nxt    = '0;
          end
          state_nxt = S_DONE;
        end
      end

      S_ACT: begin
        res_status_nxt = ST_OK;
        res_idx_nxt    = slot_r;
        res_price_nxt  = hit_price_r;
        res_qty_nxt    = hit_qty_r;
        unique case (req_kind_r)
          KIND_ADJUST: begin
            wr.qty_we   = 1'b1;
            wr.qty      = alu_res;
            res_qty_nxt = alu_res;
          end
          KIND_SET: begin
            wr.price_we   = 1'b1;
            wr.price      = req_price_r;
            res_price_nxt = req_price_r;
          end
          default: ;
        endcase
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_r || out_chan.ready) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = idx_ext[ENTRY_IDX_W-1:0];
          out_price_nxt  = res_price_r;
          out_qty_nxt    = res_qty_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_kind_r   <= req_kind_nxt;
    req_key_r    <= req_key_nxt;
    req_price_r  <= req_price_nxt;
    req_qty_r    <= req_qty_nxt;
    scan_r       <= scan_nxt;
    cmp_addr_r   <= cmp_addr_nxt;
    slot_r       <= slot_nxt;
    hit_price_r  <= hit_price_nxt;
    hit_qty_r    <= hit_qty_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_price_r  <= res_price_nxt;
    res_qty_r    <= res_qty_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_price_r  <= out_price_nxt;
    out_qty_r    <= out_qty_nxt;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count beyond table depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("entry count moved by other than one");

  a_slot_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACT) |-> ({{(CNTW-IDXW){1'b0}}, slot_r} < cnt_r))
    else $error("matched slot outside filled entries");

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.key_we || wr.price_we || wr.qty_we) |-> (state_r == S_SCAN || state_r == S_ACT))
    else $error("table write outside scan or update");
`endif

endmodule
`default_nettype wire

### sim/keyed_record_table_test.sv
`timescale 1ns / 1ps
module keyed_record_table_test;
  import krt_pkg::*;

  localparam int      DEPTH        = TABLE_DEPTH_DEF;
  localparam int      RANDOM_ITEMS = 1350;
  localparam int      DRAIN_CYCLES = DEPTH + 40;
  localparam longint  CYCLE_LIMIT  = 3000000;
  localparam word_t   W_MIN        = 32'sh80000000;
  localparam word_t   W_MAX        = 32'sh7fffffff;

  typedef struct packed {
    kind_t kind;
    word_t key;
    word_t price;
    word_t qty;
  } request_t;

  typedef struct packed {
    status_t                status;
    logic [ENTRY_IDX_W-1:0] index;
    word_t                  price;
    word_t                  qty;
  } record_rsp_t;

  typedef struct packed {
    request_t    req;
    logic        typed;
    record_rsp_t rsp;
  } table_row_t;

  localparam record_rsp_t NO_RSP = '0;
  localparam record_rsp_t NF_RSP = '{ST_NOT_FOUND, 7'd0, 32'sd0, 32'sd0};
  localparam record_rsp_t EX_RSP = '{ST_EXISTS, 7'd0, 32'sd0, 32'sd0};

  // typed rows carry a result readable by eye, the rest go through the predictor
  table_row_t directed_rows [25] = '{
    '{'{KIND_LOOKUP, 32'sd0, 32'sd0, 32'sd0}, 1'b1, NF_RSP},
    '{'{KIND_ADJUST, 32'sd5, 32'sd0, 32'sd7}, 1'b1, NF_RSP},
    '{'{KIND_SET, -32'sd1, 32'sd9, 32'sd0}, 1'b1, NF_RSP},
    '{'{KIND_INSERT, W_MIN, W_MAX, W_MIN}, 1'b1, '{ST_OK, 7'd0, W_MAX, W_MIN}},
    '{'{KIND_INSERT, W_MAX, W_MIN, W_MAX}, 1'b1, '{ST_OK, 7'd1, W_MIN, W_MAX}},
    '{'{KIND_INSERT, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{ST_OK, 7'd2, 32'sd0, 32'sd0}},
    '{'{KIND_INSERT, -32'sd1, -32'sd1, -32'sd1}, 1'b1, '{ST_OK, 7'd3, -32'sd1, -32'sd1}},
    '{'{KIND_INSERT, W_MIN, 32'sd1, 32'sd1}, 1'b1, EX_RSP},
    '{'{KIND_INSERT, 32'sd0, 32'sd5, 32'sd5}, 1'b1, EX_RSP},
    '{'{KIND_LOOKUP, W_MAX, 32'sd0, 32'sd0}, 1'b1, '{ST_OK, 7'd1, W_MIN, W_MAX}},
    // quantity pinned at the top and bottom bounds
    '{'{KIND_ADJUST, W_MAX, 32'sd0, 32'sd1}, 1'b1, '{ST_OK, 7'd1, W_MIN, W_MAX}},
    '{'{KIND_ADJUST, W_MIN, 32'sd0, -32'sd1}, 1'b1, '{ST_OK, 7'd0, W_MAX, W_MIN}},
    '{'{KIND_ADJUST, W_MIN, 32'sd0, W_MAX}, 1'b0, NO_RSP},
    '{'{KIND_ADJUST, -32'sd1, 32'sd0, W_MIN}, 1'b0, NO_RSP},
    '{'{KIND_SET, 32'sd0, 32'sh12345678, 32'sd0}, 1'b0, NO_RSP},
    '{'{KIND_LOOKUP, 32'sh7ffffffe, 32'sd0, 32'sd0}, 1'b1, NF_RSP},
    '{'{KIND_LOOKUP, 32'sd1, 32'sd0, 32'sd0}, 1'b1, NF_RSP},
    '{'{KIND_ADJUST, 32'sd0, 32'sd0, W_MAX}, 1'b0, NO_RSP},
    '{'{KIND_ADJUST, 32'sd0, 32'sd0, W_MAX}, 1'b0, NO_RSP},
    '{'{KIND_ADJUST, -32'sd1, 32'sd0, W_MAX}, 1'b0, NO_RSP},
    '{'{KIND_SET, -32'sd1, W_MIN, 32'sd0}, 1'b0, NO_RSP},
    '{'{KIND_LOOKUP, -32'sd1, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
    '{'{KIND_LOOKUP, 32'sh80000001, 32'sd0, 32'sd0}, 1'b1, NF_RSP},
    '{'{KIND_INSERT, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555}, 1'b0, NO_RSP},
    '{'{KIND_SET, W_MAX, W_MAX, 32'sd0}, 1'b0, NO_RSP}
  };

  logic clk = 1'b0;
  logic rst_n;

  always #6 clk = ~clk;

  krt_in_if  in_chan ();
  krt_out_if out_chan ();

  keyed_record_table #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // shadow copy of the table
  word_t       slot_key   [DEPTH];
  word_t       slot_price [DEPTH];
  word_t       slot_qty   [DEPTH];
  int unsigned fill_count = 0;

  record_rsp_t  pending_rsp [$];
  int unsigned  fail_count  = 0;
  longint       cycle_count = 0;

  function automatic word_t sat_sum(word_t a, word_t b);
    logic [32:0] wide;
    wide = {a[31], a} + {b[31], b};
    if (wide[32] != wide[31]) return wide[32] ? W_MIN : W_MAX;
    return wide[31:0];
  endfunction

  function automatic record_rsp_t apply_request(request_t r);
    record_rsp_t res;
    int unsigned slot;
    bit          hit;
    res  = '0;
    slot = 0;
    hit  = 1'b0;
    // first match in insertion order
    for (int unsigned i = 0; i < fill_count; i++) begin
      if (!hit && slot_key[i] == r.key) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    if (r.kind == KIND_INSERT) begin
      // a full table wins over a duplicate key
      if (fill_count >= DEPTH) begin
        res.status = ST_FULL;
      end else if (hit) begin
        res.status = ST_EXISTS;
      end else begin
        slot             = fill_count;
        slot_key[slot]   = r.key;
        slot_price[slot] = r.price;
        slot_qty[slot]   = r.qty;
        fill_count++;
        res.status = ST_OK;
      end
    end else if (!hit) begin
      res.status = ST_NOT_FOUND;
    end else begin
      if (r.kind == KIND_ADJUST) slot_qty[slot] = sat_sum(slot_qty[slot], r.qty);
      else if (r.kind == KIND_SET) slot_price[slot] = r.price;
      res.status = ST_OK;
    end
    if (res.status == ST_OK) begin
      res.index = slot[ENTRY_IDX_W-1:0];
      res.price = slot_price[slot];
      res.qty   = slot_qty[slot];
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 150);
  endfunction

  function automatic word_t corner_word();
    case ($urandom_range(0, 5))
      0:       return W_MIN;
      1:       return W_MAX;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4:       return 32'sd1;
      default: return W_MIN + 32'sd1;
    endcase
  endfunction

  function automatic word_t pick_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return corner_word();
    if (pick < 50) return word_t'($urandom_range(0, 2000)) - 32'sd1000;
    return $urandom;
  endfunction

  // stored keys, one-bit near misses, corners and plain noise
  function automatic word_t pick_key(int unsigned hit_pct);
    word_t       stored;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (fill_count != 0) stored = slot_key[$urandom_range(0, fill_count - 1)];
    else stored = $urandom;
    if (pick < hit_pct && fill_count != 0) return stored;
    if (pick < hit_pct + 10) return stored ^ (32'h1 << $urandom_range(0, 31));
    if (pick < hit_pct + 18) return corner_word();
    return $urandom;
  endfunction

  function automatic request_t random_request(int unsigned item_no);
    request_t    r;
    int unsigned insert_pct;
    // fill slowly, then push to a full table before the end
    if (fill_count >= DEPTH) insert_pct = 10;
    else if (item_no > 1000) insert_pct = 60;
    else insert_pct = 14;
    if ($urandom_range(0, 99) < insert_pct) begin
      r.kind = KIND_INSERT;
    end else begin
      case ($urandom_range(0, 2))
        0:       r.kind = KIND_LOOKUP;
        1:       r.kind = KIND_ADJUST;
        default: r.kind = KIND_SET;
      endcase
    end
    r.key   = pick_key((r.kind == KIND_INSERT) ? 20 : 65);
    r.price = pick_value();
    r.qty   = pick_value();
    return r;
  endfunction

  task automatic send_request(request_t r, logic typed, record_rsp_t typed_rsp);
    record_rsp_t predicted;
    in_chan.valid          <= 1'b1;
    in_chan.kind           <= r.kind;
    in_chan.part_key       <= r.key;
    in_chan.price_value    <= r.price;
    in_chan.quantity_value <= r.qty;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    predicted = apply_request(r);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic pause_sender(int unsigned cycles);
    if (cycles != 0) begin
      in_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  initial begin : request_drive
    bit sender_idles;
    sender_idles           = 1'b1;
    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.kind           <= KIND_LOOKUP;
    in_chan.part_key       <= '0;
    in_chan.price_value    <= '0;
    in_chan.quantity_value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      if ($urandom_range(0, 99) < 30) pause_sender(pick_gap());
    end
    wait_drained();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) sender_idles = ($urandom_range(0, 3) != 0);
      // hold off until the table has answered everything in flight
      if (n != 0 && n % 300 == 0) wait_drained();
      send_request(random_request(n), 1'b0, NO_RSP);
      if (sender_idles && $urandom_range(0, 99) < 30) pause_sender(pick_gap());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[keyed_record_table] OK");
    end else begin
      $display("[keyed_record_table] ERROR");
    end
    $finish;
  end

  initial begin : result_ready_drive
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_chan.ready <= 1'b1;
      if ($urandom_range(0, 99) < 15) repeat ($urandom_range(300, 800)) @(posedge clk);
      else repeat ($urandom_range(1, 60)) @(posedge clk);
      out_chan.ready <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    record_rsp_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected transfer: status %0d entry_index %0d", out_chan.status,
               out_chan.entry_index);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_chan.status);
          fail_count++;
        end
        if (out_chan.entry_index !== want.index) begin
          $error("entry_index: expected %0d, got %0d", want.index, out_chan.entry_index);
          fail_count++;
        end
        if (out_chan.price_out !== want.price) begin
          $error("price_out: expected %0d, got %0d", want.price, out_chan.price_out);
          fail_count++;
        end
        if (out_chan.quantity_out !== want.qty) begin
          $error("quantity_out: expected %0d, got %0d", want.qty, out_chan.quantity_out);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[keyed_record_table] ERROR");
      $finish;
    end
  end

endmodule

### files.f
src/krt_pkg.sv
src/krt_if.sv
src/krt_alu.sv
src/krt_store.sv
src/keyed_record_table.sv
sim/keyed_record_table_test.sv
